[rtl/gap_buffer_line_editor_macros.svh]
// assertion macros for the gap buffer line editor
// used by the top level only; expects signals named clk and rst in scope
`ifndef GAP_BUFFER_LINE_EDITOR_MACROS_SVH
`define GAP_BUFFER_LINE_EDITOR_MACROS_SVH

// condition holds in the same cycle as the trigger
`define GBE_CHECK_NOW(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// condition holds in the cycle after the trigger
`define GBE_CHECK_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

[rtl/gbe_pkg.sv]
// shared types and constants for the gap buffer line editor
// no dependencies
`default_nettype none

package gbe_pkg;

  localparam int AMT_W  = 13;
  localparam int CHAR_W = 8;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_LEFT   = 2'd2,
    CMD_RIGHT  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_XFER,
    ST_WIN
  } state_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [CHAR_W-1:0] char_code;
    logic [AMT_W-1:0]  amount;
  } request_t;

  typedef struct packed {
    logic [AMT_W-1:0]  count;
    logic              char_valid;
    logic [CHAR_W-1:0] char_out;
    logic              last;
    logic              buffer_full;
  } result_t;

  // result request from the sequencer to the output stage
  typedef struct packed {
    logic             vld;
    logic             win;
    logic             last;
    logic             full;
    logic [AMT_W-1:0] count;
  } emit_t;

endpackage

`default_nettype wire

[rtl/gbe_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module gbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/gbe_seq.sv]
// command sequencer: cursor counts, stack transfer and window readout
// depends on gbe_pkg; drives the text ram ports
`default_nettype none

module gbe_seq #(
  parameter int CAPACITY = 4096,
  parameter int WINDOW   = 10
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire gbe_pkg::request_t           request,
  output      logic                        busy,
  output      gbe_pkg::emit_t              emit,
  output      logic                        ram_we,
  output      logic [$clog2(CAPACITY)-1:0] ram_waddr,
  output      logic [gbe_pkg::CHAR_W-1:0]  ram_wdata,
  output      logic                        ram_re,
  output      logic [$clog2(CAPACITY)-1:0] ram_raddr,
  input  wire logic [gbe_pkg::CHAR_W-1:0]  ram_rdata
);

  localparam int AMT_W = gbe_pkg::AMT_W;
  localparam int AW    = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int WW    = $clog2(WINDOW + 1);
  localparam int MW    = (CW > AMT_W) ? CW : AMT_W;
  localparam int NW    = (CW > WW) ? CW : WW;

  gbe_pkg::state_t   state, state_next;
  logic [CW-1:0]     left_cnt, left_cnt_next;
  logic [CW-1:0]     right_cnt, right_cnt_next;
  logic              dir_right, dir_right_next;
  logic [AMT_W-1:0]  step_cnt, step_cnt_next;
  logic [AMT_W-1:0]  moved, moved_next;
  logic              pend, pend_next;
  logic              pend_last, pend_last_next;
  logic [AW-1:0]     src_ptr, src_ptr_next;
  logic [AW-1:0]     dst_ptr, dst_ptr_next;
  logic [WW-1:0]     win_left, win_left_next;
  logic [AW-1:0]     win_ptr, win_ptr_next;

  // clamped amount and new cursor position for the accepted word
  logic [AMT_W-1:0]  clamp_l, clamp_r, move_dist;
  logic [CW-1:0]     left_new;
  logic [WW-1:0]     win_n;
  logic              is_full;

  always_comb begin
    clamp_l = (MW'(request.amount) < MW'(left_cnt)) ? request.amount : AMT_W'(left_cnt);
    clamp_r = (MW'(request.amount) < MW'(right_cnt)) ? request.amount : AMT_W'(right_cnt);
    move_dist = (request.command == gbe_pkg::CMD_RIGHT) ? clamp_r : clamp_l;
    left_new = (request.command == gbe_pkg::CMD_RIGHT) ? left_cnt + CW'(move_dist)
                                                       : left_cnt - CW'(move_dist);
    win_n   = (NW'(left_new) < NW'(WINDOW)) ? WW'(left_new) : WW'(WINDOW);
    is_full = ((CW+1)'(left_cnt) + (CW+1)'(right_cnt)) >= (CW+1)'(CAPACITY);
  end

  // state and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gbe_pkg::ST_IDLE;
      left_cnt  <= '0;
      right_cnt <= '0;
      pend      <= 1'b0;
      pend_last <= 1'b0;
    end else begin
      state     <= state_next;
      left_cnt  <= left_cnt_next;
      right_cnt <= right_cnt_next;
      pend      <= pend_next;
      pend_last <= pend_last_next;
    end
  end

  always_ff @(posedge clk) begin
    dir_right <= dir_right_next;
    step_cnt  <= step_cnt_next;
    moved     <= moved_next;
    src_ptr   <= src_ptr_next;
    dst_ptr   <= dst_ptr_next;
    win_left  <= win_left_next;
    win_ptr   <= win_ptr_next;
  end

  assign busy = (state != gbe_pkg::ST_IDLE);

  // next state, ram accesses and result requests
  always_comb begin
    state_next     = state;
    left_cnt_next  = left_cnt;
    right_cnt_next = right_cnt;
    dir_right_next = dir_right;
    step_cnt_next  = step_cnt;
    moved_next     = moved;
    pend_next      = 1'b0;
    pend_last_next = 1'b0;
    src_ptr_next   = src_ptr;
    dst_ptr_next   = dst_ptr;
    win_left_next  = win_left;
    win_ptr_next   = win_ptr;
    emit           = '0;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = request.char_code;
    ram_re         = 1'b0;
    ram_raddr      = '0;

    case (state)
      gbe_pkg::ST_IDLE: begin
        if (start) begin
          case (request.command)
            gbe_pkg::CMD_INSERT: begin
              emit.vld  = 1'b1;
              emit.last = 1'b1;
              if (is_full) begin
                emit.full = 1'b1;
              end else begin
                ram_we        = 1'b1;
                ram_waddr     = AW'(left_cnt);
                left_cnt_next = left_cnt + CW'(1);
                emit.count    = AMT_W'(1);
              end
            end
            gbe_pkg::CMD_DELETE: begin
              left_cnt_next = left_cnt - CW'(clamp_l);
              emit.vld      = 1'b1;
              emit.last     = 1'b1;
              emit.count    = clamp_l;
            end
            default: begin
              // cursor moves: set up transfer, then window readout
              dir_right_next = (request.command == gbe_pkg::CMD_RIGHT);
              step_cnt_next  = move_dist;
              moved_next     = move_dist;
              left_cnt_next  = left_new;
              if (request.command == gbe_pkg::CMD_RIGHT) begin
                right_cnt_next = right_cnt - CW'(move_dist);
                src_ptr_next   = AW'(CW'(CAPACITY) - right_cnt);
                dst_ptr_next   = AW'(left_cnt);
              end else begin
                right_cnt_next = right_cnt + CW'(move_dist);
                src_ptr_next   = AW'(left_cnt - CW'(1));
                dst_ptr_next   = AW'(CW'(CAPACITY) - right_cnt - CW'(1));
              end
              win_left_next = win_n;
              win_ptr_next  = AW'(left_new - CW'(win_n));
              state_next    = (move_dist != '0) ? gbe_pkg::ST_XFER : gbe_pkg::ST_WIN;
            end
          endcase
        end
      end

      gbe_pkg::ST_XFER: begin
        // read one source character per cycle, write it back in the following cycle
        if (step_cnt != '0) begin
          ram_re        = 1'b1;
          ram_raddr     = src_ptr;
          src_ptr_next  = dir_right ? src_ptr + AW'(1) : src_ptr - AW'(1);
          step_cnt_next = step_cnt - AMT_W'(1);
          pend_next     = 1'b1;
        end
        if (pend) begin
          ram_we       = 1'b1;
          ram_waddr    = dst_ptr;
          ram_wdata    = ram_rdata;
          dst_ptr_next = dir_right ? dst_ptr + AW'(1) : dst_ptr - AW'(1);
        end
        if (step_cnt == '0) begin
          state_next = gbe_pkg::ST_WIN;
        end
      end

      gbe_pkg::ST_WIN: begin
        // stream the window characters, leftmost first
        if (win_left != '0) begin
          ram_re         = 1'b1;
          ram_raddr      = win_ptr;
          win_ptr_next   = win_ptr + AW'(1);
          win_left_next  = win_left - WW'(1);
          pend_next      = 1'b1;
          pend_last_next = (win_left == WW'(1));
        end
        if (pend) begin
          emit.vld   = 1'b1;
          emit.win   = 1'b1;
          emit.last  = pend_last;
          emit.count = moved;
        end
        if (win_left == '0) begin
          if (!pend) begin
            // empty mark: nothing left of the cursor
            emit.vld   = 1'b1;
            emit.last  = 1'b1;
            emit.count = moved;
          end
          state_next = gbe_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = gbe_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/gap_buffer_line_editor.sv]
// Gap buffer line editor: one text line with a cursor, two stacks in one ram.
// Insert and delete: the result is registered at the accepting edge; busy stays low,
// so a new word can start every cycle. A move keeps busy high through the stack
// transfer, one ram read and one ram write per cycle, and the window readout;
// window results pass through the registered ram read and the output register.
// Synchronous reset empties the line (both counts zero); ram contents are not cleared.
`default_nettype none

`include "gap_buffer_line_editor_macros.svh"

module gap_buffer_line_editor #(
  parameter int CAPACITY = 4096,
  parameter int WINDOW   = 10
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire gbe_pkg::request_t request,
  output      logic              busy,
  output      logic              done,
  output      gbe_pkg::result_t  result
);

  localparam int AW = $clog2(CAPACITY);

  gbe_pkg::emit_t              emit;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [gbe_pkg::CHAR_W-1:0]  ram_wdata;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic [gbe_pkg::CHAR_W-1:0]  ram_rdata;

  gbe_seq #(
    .CAPACITY (CAPACITY),
    .WINDOW   (WINDOW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .request   (request),
    .busy      (busy),
    .emit      (emit),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  gbe_ram #(
    .WIDTH (gbe_pkg::CHAR_W),
    .DEPTH (CAPACITY)
  ) u_text_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register: one word per strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= emit.vld;
    end
  end

  always_ff @(posedge clk) begin
    result.count       <= emit.count;
    result.char_valid  <= emit.win;
    result.char_out    <= emit.win ? ram_rdata : '0;
    result.last        <= emit.last;
    result.buffer_full <= emit.full;
  end

  // checks
  `GBE_CHECK_NOW(a_no_rw_collision, ram_we && ram_re, ram_waddr != ram_raddr, "ram read and write hit the same entry")
  `GBE_CHECK_NEXT(a_single_result, start && !busy && (request.command == gbe_pkg::CMD_INSERT || request.command == gbe_pkg::CMD_DELETE), done && result.last, "insert or delete result missing")
  `GBE_CHECK_NEXT(a_window_burst, done && !result.last, done && result.char_valid, "window words not back to back")
  `GBE_CHECK_NOW(a_full_count, done && result.buffer_full, result.count == '0 && !result.char_valid, "dropped insert reports a count")

endmodule

`default_nettype wire
